// ===== rtl/core/point_cloud_bounds_and_centroid_macros.svh =====
// ----------------------------------------------------------------------------
// point_cloud_bounds_and_centroid_macros
// Assertion macros shared by the point cloud bounds block.
// ----------------------------------------------------------------------------
`ifndef POINT_CLOUD_BOUNDS_AND_CENTROID_MACROS_SVH
`define POINT_CLOUD_BOUNDS_AND_CENTROID_MACROS_SVH

// Check a condition at every clock edge outside reset
`define PCB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define PCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that a condition implies another in the same cycle
`define PCB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/pcb_pkg.sv =====
// ----------------------------------------------------------------------------
// pcb_pkg
// Types, widths and helpers for the point cloud bounds and centroid block.
// ----------------------------------------------------------------------------
package pcb_pkg;

  // Point limit per cloud and the widths that follow from it
  localparam int MAX_POINTS = 1048576;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = 32 + $clog2(MAX_POINTS);
  localparam int UNIT_W     = SUM_W + 1;
  localparam int DQ_W       = SUM_W - 1;
  localparam int STEP_W     = $clog2(SUM_W);

  // Input word: one point
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] intensity;
    logic               last_point;
  } pcb_pt_t;

  // Output word: box, centre and overflow flag of one cloud
  typedef struct packed {
    logic signed [31:0] low_x;
    logic signed [31:0] low_y;
    logic signed [31:0] low_z;
    logic        [15:0] low_intensity;
    logic signed [31:0] high_x;
    logic signed [31:0] high_y;
    logic signed [31:0] high_z;
    logic        [15:0] high_intensity;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic               too_many_points;
  } pcb_res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINMAX,
    ST_SUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_STORE,
    ST_DONE
  } pcb_state_t;

  // Sign-extend a coordinate to the shared unit width
  function automatic logic [UNIT_W-1:0] sext_coord(input logic [31:0] v);
    return {{(UNIT_W-32){v[31]}}, v};
  endfunction

  // Zero-extend an intensity to the shared unit width
  function automatic logic [UNIT_W-1:0] zext_int(input logic [15:0] v);
    return {{(UNIT_W-16){1'b0}}, v};
  endfunction

  // Sign-extend a running sum to the shared unit width
  function automatic logic [UNIT_W-1:0] sext_sum(input logic [SUM_W-1:0] v);
    return {{(UNIT_W-SUM_W){v[SUM_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/core/point_cloud_bounds_and_centroid.sv =====
// Flow: a point is accepted in the idle state, then takes eight compare steps
// and three sum steps on the single shared adder before the next ready.
// A last point adds the three bit-serial mean divisions on the same adder,
// plus any wait for a free output register. Reset (rst, synchronous) clears
// the sums, count and flags.
// ----------------------------------------------------------------------------
// point_cloud_bounds_and_centroid
// Running bounding box, coordinate sums and point count over a point cloud;
// on the last point, returns the box and the floor of each coordinate mean.
// ----------------------------------------------------------------------------
`include "point_cloud_bounds_and_centroid_macros.svh"

module point_cloud_bounds_and_centroid import pcb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     pt_valid,
  output logic     pt_ready,
  input  pcb_pt_t  pt,
  output logic     res_valid,
  input  logic     res_ready,
  output pcb_res_t res
);

  localparam logic [STEP_W-1:0] MM_LAST  = STEP_W'(7);
  localparam logic [STEP_W-1:0] SUM_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DQ_W - 1);
  localparam logic [1:0]        AXIS_Z   = 2'd2;

  pcb_state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic [1:0]        axis;

  pcb_pt_t pt_q;
  logic    have_point;

  logic signed [31:0] run_min_x, run_min_y, run_min_z;
  logic signed [31:0] run_max_x, run_max_y, run_max_z;
  logic        [15:0] run_min_intensity, run_max_intensity;
  logic [SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]   point_count;
  logic               overflow_seen;

  logic [DQ_W-1:0]    dq;
  logic [CNT_W-1:0]   rem;
  logic               div_neg;
  logic [CNT_W:0]     div_in;
  logic [31:0]        cen_x, cen_y, cen_z;
  logic [31:0]        quot;

  logic [UNIT_W-1:0]  unit_a, unit_b, unit_res;
  logic               unit_sub;
  logic [UNIT_W-1:0]  cur_v, lo_v, hi_v, sum_v, coord_v;
  logic [SUM_W-1:0]   div_src;
  logic               take, fits, room, out_free, accept;

  // Handshake terms
  assign accept   = pt_valid && pt_ready;
  assign out_free = !res_valid || res_ready;
  assign room     = point_count < CNT_W'(MAX_POINTS);

  // Shared adder: add, or subtract with the sign as the borrow flag
  assign unit_res = unit_a + (unit_sub ? ~unit_b : unit_b) + UNIT_W'(unit_sub);
  assign take     = !have_point || unit_res[UNIT_W-1];
  assign fits     = !unit_res[UNIT_W-1];
  assign div_in   = {rem, dq[DQ_W-1]};
  assign quot     = div_neg ? ~32'(dq) : 32'(dq);

  // Select the field under test and its running bounds
  always_comb begin
    cur_v = '0;
    lo_v  = '0;
    hi_v  = '0;
    case (step[2:1])
      2'd0: begin
        cur_v = sext_coord(pt_q.pos_x);
        lo_v  = sext_coord(run_min_x);
        hi_v  = sext_coord(run_max_x);
      end
      2'd1: begin
        cur_v = sext_coord(pt_q.pos_y);
        lo_v  = sext_coord(run_min_y);
        hi_v  = sext_coord(run_max_y);
      end
      2'd2: begin
        cur_v = sext_coord(pt_q.pos_z);
        lo_v  = sext_coord(run_min_z);
        hi_v  = sext_coord(run_max_z);
      end
      default: begin
        cur_v = zext_int(pt_q.intensity);
        lo_v  = zext_int(run_min_intensity);
        hi_v  = zext_int(run_max_intensity);
      end
    endcase
  end

  // Select the sum and coordinate of the current axis
  always_comb begin
    sum_v   = sext_sum(sum_x);
    coord_v = sext_coord(pt_q.pos_x);
    case (step[1:0])
      2'd0: begin
        sum_v   = sext_sum(sum_x);
        coord_v = sext_coord(pt_q.pos_x);
      end
      2'd1: begin
        sum_v   = sext_sum(sum_y);
        coord_v = sext_coord(pt_q.pos_y);
      end
      default: begin
        sum_v   = sext_sum(sum_z);
        coord_v = sext_coord(pt_q.pos_z);
      end
    endcase
  end

  // Select the dividend of the current axis
  always_comb begin
    case (axis)
      2'd0:    div_src = sum_x;
      2'd1:    div_src = sum_y;
      default: div_src = sum_z;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (pt_valid) state_next = ST_MINMAX;
      ST_MINMAX:    if (step == MM_LAST) state_next = ST_SUM;
      ST_SUM: begin
        if (step == SUM_LAST) state_next = pt_q.last_point ? ST_DIV_LOAD : ST_IDLE;
      end
      ST_DIV_LOAD:  state_next = ST_DIV;
      ST_DIV:       if (step == DIV_LAST) state_next = ST_DIV_STORE;
      ST_DIV_STORE: state_next = (axis == AXIS_Z) ? ST_DONE : ST_DIV_LOAD;
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: ready and shared adder operands
  always_comb begin
    pt_ready = 1'b0;
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b1;
    case (state)
      ST_IDLE: pt_ready = 1'b1;
      ST_MINMAX: begin
        unit_a = step[0] ? hi_v : cur_v;
        unit_b = step[0] ? cur_v : lo_v;
      end
      ST_SUM: begin
        unit_a   = sum_v;
        unit_b   = coord_v;
        unit_sub = 1'b0;
      end
      ST_DIV: begin
        unit_a = UNIT_W'(div_in);
        unit_b = UNIT_W'(point_count);
      end
      default: pt_ready = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      axis          <= '0;
      have_point    <= 1'b0;
      point_count   <= '0;
      overflow_seen <= 1'b0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + STEP_W'(1);

      // Advance the axis after each stored mean
      if (state == ST_DIV_STORE) begin
        axis <= (axis == AXIS_Z) ? 2'd0 : axis + 2'd1;
      end

      if (state == ST_MINMAX && step == MM_LAST) begin
        have_point <= 1'b1;
      end

      // Accumulate sums while the count has room, else flag the overflow
      if (state == ST_SUM) begin
        if (room) begin
          case (step[1:0])
            2'd0:    sum_x <= unit_res[SUM_W-1:0];
            2'd1:    sum_y <= unit_res[SUM_W-1:0];
            default: sum_z <= unit_res[SUM_W-1:0];
          endcase
        end
        if (step == SUM_LAST) begin
          if (room) point_count <= point_count + CNT_W'(1);
          else      overflow_seen <= 1'b1;
        end
      end

      // Hand the result over and clear the cloud
      if (state == ST_DONE && out_free) begin
        res_valid     <= 1'b1;
        have_point    <= 1'b0;
        point_count   <= '0;
        overflow_seen <= 1'b0;
        sum_x         <= '0;
        sum_y         <= '0;
        sum_z         <= '0;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Data path registers
  always_ff @(posedge clk) begin
    if (accept) pt_q <= pt;

    // Update a bound when the compare says so
    if (state == ST_MINMAX && take) begin
      case (step[2:0])
        3'd0:    run_min_x         <= pt_q.pos_x;
        3'd1:    run_max_x         <= pt_q.pos_x;
        3'd2:    run_min_y         <= pt_q.pos_y;
        3'd3:    run_max_y         <= pt_q.pos_y;
        3'd4:    run_min_z         <= pt_q.pos_z;
        3'd5:    run_max_z         <= pt_q.pos_z;
        3'd6:    run_min_intensity <= pt_q.intensity;
        default: run_max_intensity <= pt_q.intensity;
      endcase
    end

    // Load the magnitude form of the dividend: floor(s/c) = ~(~s / c) for s < 0
    if (state == ST_DIV_LOAD) begin
      div_neg <= div_src[SUM_W-1];
      dq      <= div_src[SUM_W-1] ? ~div_src[DQ_W-1:0] : div_src[DQ_W-1:0];
      rem     <= '0;
    end

    // One restoring division step per cycle
    if (state == ST_DIV) begin
      rem <= fits ? unit_res[CNT_W-1:0] : div_in[CNT_W-1:0];
      dq  <= {dq[DQ_W-2:0], fits};
    end

    // Store the mean of the finished axis
    if (state == ST_DIV_STORE) begin
      case (axis)
        2'd0:    cen_x <= quot;
        2'd1:    cen_y <= quot;
        default: cen_z <= quot;
      endcase
    end

    // Load the output word
    if (state == ST_DONE && out_free) begin
      res.low_x           <= run_min_x;
      res.low_y           <= run_min_y;
      res.low_z           <= run_min_z;
      res.low_intensity   <= run_min_intensity;
      res.high_x          <= run_max_x;
      res.high_y          <= run_max_y;
      res.high_z          <= run_max_z;
      res.high_intensity  <= run_max_intensity;
      res.centre_x        <= cen_x;
      res.centre_y        <= cen_y;
      res.centre_z        <= cen_z;
      res.too_many_points <= overflow_seen;
    end
  end

  // Checks on the sequencer and the divider
  `PCB_ASSERT_NEXT(a_accept_starts, accept, state == ST_MINMAX && step == '0, "accept did not start compare")
  `PCB_ASSERT_SAME(a_res_from_done, $rose(res_valid), $past(state) == ST_DONE, "result word loaded outside done")
  `PCB_ASSERT_SAME(a_overflow_full, overflow_seen, point_count == CNT_W'(MAX_POINTS), "overflow without full count")
  `PCB_ASSERT_SAME(a_rem_below_count, state == ST_DIV, rem < point_count, "division remainder not below count")

endmodule

// ===== verif/point_cloud_bounds_and_centroid_tb.sv =====
// ----------------------------------------------------------------------------
// point_cloud_bounds_and_centroid_tb
// Streams point clouds into the bounds and centroid block and checks every
// reported box, floored mean and overflow flag against a cycle-free model
// kept in the bench. Directed clouds cover full-scale coordinates, single
// points, negative means that need flooring, and clouds of one sign; random
// clouds follow under changing backpressure on both channels.
// ----------------------------------------------------------------------------
module point_cloud_bounds_and_centroid_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcb_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;

  logic     clk;
  logic     rst;
  logic     pt_valid;
  logic     pt_ready;
  pcb_pt_t  pt;
  logic     res_valid;
  logic     res_ready;
  pcb_res_t res;

  int send_idle_pct;
  int recv_idle_pct;
  int n_errors = 0;

  // Running box, sums and count of the cloud being collected
  logic signed [31:0]      lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic        [15:0]      lo_int, hi_int;
  logic signed [SUM_W-1:0] tot_x, tot_y, tot_z;
  logic        [CNT_W-1:0] n_pts;
  logic                    capped;
  logic                    cloud_open;
  pcb_res_t                clouds_due[$];
  pcb_res_t                cloud_want;

  point_cloud_bounds_and_centroid dut (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_cloud();
    lo_x = '0; lo_y = '0; lo_z = '0; lo_int = '0;
    hi_x = '0; hi_y = '0; hi_z = '0; hi_int = '0;
    tot_x = '0; tot_y = '0; tot_z = '0;
    n_pts = '0;
    capped = 1'b0;
    cloud_open = 1'b0;
  endfunction

  // Round the mean toward minus infinity
  function automatic logic [31:0] floor_mean(input logic signed [SUM_W-1:0] total,
                                             input logic [CNT_W-1:0] n);
    longint s, c, q;
    s = total;
    c = (n == 0) ? 1 : n;
    q = s / c;
    if (s % c != 0 && s < 0) q = q - 1;
    return q[31:0];
  endfunction

  // Fold one accepted point into the cloud; queue the report on a last point
  function automatic void fold_point(input pcb_pt_t p);
    pcb_res_t r;
    if (!cloud_open) begin
      lo_x = p.pos_x; hi_x = p.pos_x;
      lo_y = p.pos_y; hi_y = p.pos_y;
      lo_z = p.pos_z; hi_z = p.pos_z;
      lo_int = p.intensity; hi_int = p.intensity;
      cloud_open = 1'b1;
    end else begin
      if ($signed(p.pos_x) < lo_x) lo_x = p.pos_x;
      if ($signed(p.pos_y) < lo_y) lo_y = p.pos_y;
      if ($signed(p.pos_z) < lo_z) lo_z = p.pos_z;
      if (p.intensity < lo_int) lo_int = p.intensity;
      if ($signed(p.pos_x) > hi_x) hi_x = p.pos_x;
      if ($signed(p.pos_y) > hi_y) hi_y = p.pos_y;
      if ($signed(p.pos_z) > hi_z) hi_z = p.pos_z;
      if (p.intensity > hi_int) hi_int = p.intensity;
    end
    // Stop the sums at the point limit, flag anything past it
    if (n_pts < MAX_POINTS) begin
      tot_x = tot_x + $signed(p.pos_x);
      tot_y = tot_y + $signed(p.pos_y);
      tot_z = tot_z + $signed(p.pos_z);
      n_pts = n_pts + 1'b1;
    end else begin
      capped = 1'b1;
    end
    if (p.last_point) begin
      r.low_x = lo_x;  r.low_y = lo_y;  r.low_z = lo_z;  r.low_intensity = lo_int;
      r.high_x = hi_x; r.high_y = hi_y; r.high_z = hi_z; r.high_intensity = hi_int;
      r.centre_x = floor_mean(tot_x, n_pts);
      r.centre_y = floor_mean(tot_y, n_pts);
      r.centre_z = floor_mean(tot_z, n_pts);
      r.too_many_points = capped;
      clouds_due.push_back(r);
      clear_cloud();
    end
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // Compare each result word with the oldest report due; stall at random
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (clouds_due.size() == 0) begin
          $error("result word with no cloud report due");
          n_errors++;
        end else begin
          cloud_want = clouds_due.pop_front();
          check_field("low_x", cloud_want.low_x, res.low_x);
          check_field("low_y", cloud_want.low_y, res.low_y);
          check_field("low_z", cloud_want.low_z, res.low_z);
          check_field("low_intensity", 32'(cloud_want.low_intensity),
                      32'(res.low_intensity));
          check_field("high_x", cloud_want.high_x, res.high_x);
          check_field("high_y", cloud_want.high_y, res.high_y);
          check_field("high_z", cloud_want.high_z, res.high_z);
          check_field("high_intensity", 32'(cloud_want.high_intensity),
                      32'(res.high_intensity));
          check_field("centre_x", cloud_want.centre_x, res.centre_x);
          check_field("centre_y", cloud_want.centre_y, res.centre_y);
          check_field("centre_z", cloud_want.centre_z, res.centre_z);
          check_field("too_many_points", 32'(cloud_want.too_many_points),
                      32'(res.too_many_points));
        end
      end
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run when neither channel moves a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((pt_valid && pt_ready) || (res_valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- sender

  function automatic pcb_pt_t point_of(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z, input logic [15:0] inten,
                                       input logic last);
    pcb_pt_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    p.intensity = inten;
    p.last_point = last;
    return p;
  endfunction

  // Idle at random, then hold the word until it is taken; valid stays high
  task automatic send_point(input pcb_pt_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_valid <= 1'b0;
      @(posedge clk);
    end
    pt_valid <= 1'b1;
    pt       <= p;
    @(posedge clk);
    while (!pt_ready) @(posedge clk);
    fold_point(p);
  endtask

  // Drop valid and hold off until every cloud report has come back
  task automatic wait_for_reports();
    pt_valid <= 1'b0;
    @(posedge clk);
    while (clouds_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3:    return $urandom_range(2000) - 1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] random_intensity();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_random_cloud(input int len);
    for (int k = 0; k < len; k++)
      send_point(point_of(random_coord(), random_coord(), random_coord(),
                          random_intensity(), k == len - 1));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_single_point_clouds();
    send_point(point_of(COORD_MIN, COORD_MAX, 32'd0, 16'h0000, 1'b1));
    send_point(point_of(COORD_MAX, COORD_MIN, -32'sd1, 16'hffff, 1'b1));
  endtask

  // Full-scale values on every axis, sums well below zero
  task automatic test_full_scale_cloud();
    send_point(point_of(COORD_MIN, COORD_MAX, -32'sd1, 16'h0000, 1'b0));
    send_point(point_of(COORD_MAX, COORD_MIN, 32'd0, 16'hffff, 1'b0));
    send_point(point_of(COORD_MIN, COORD_MIN, COORD_MIN, 16'h0001, 1'b0));
    send_point(point_of(-32'sd7, 32'd3, 32'd5, 16'h8000, 1'b1));
  endtask

  // Means of -1/3 and 2/3: floor, not truncation
  task automatic test_floor_of_mean();
    send_point(point_of(-32'sd1, 32'd1, -32'sd2, 16'h1234, 1'b0));
    send_point(point_of(32'd0, 32'd0, 32'd0, 16'h00ff, 1'b0));
    send_point(point_of(32'd0, 32'd1, 32'd1, 16'h0f00, 1'b1));
  endtask

  // The first point must load the box, not compare against zero
  task automatic test_same_sign_clouds();
    send_point(point_of(32'd100, 32'd200, 32'd300, 16'd50, 1'b0));
    send_point(point_of(32'd150, 32'd120, 32'd900, 16'd70, 1'b0));
    send_point(point_of(32'd110, 32'd400, 32'd310, 16'd60, 1'b1));
    send_point(point_of(-32'sd100, -32'sd200, -32'sd300, 16'hfff0, 1'b0));
    send_point(point_of(-32'sd150, -32'sd120, -32'sd900, 16'hfffe, 1'b0));
    send_point(point_of(-32'sd110, -32'sd400, -32'sd310, 16'hfff5, 1'b1));
  endtask

  task automatic test_pause_until_drained();
    send_random_cloud(3);
    wait_for_reports();
    send_random_cloud(1);
  endtask

  task automatic test_random_clouds(input int budget, input int s_pct, input int r_pct);
    int sent;
    int len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(19))
        0:       len = 1;
        1:       len = $urandom_range(48, 20);
        default: len = $urandom_range(8, 2);
      endcase
      send_random_cloud(len);
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst       <= 1'b1;
    pt_valid  <= 1'b0;
    pt        <= '0;
    send_idle_pct = 35;
    recv_idle_pct = 66;
    clear_cloud();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_single_point_clouds();
    test_full_scale_cloud();
    test_floor_of_mean();
    test_same_sign_clouds();
    test_pause_until_drained();
    test_random_clouds(430, 35, 66);
    test_random_clouds(430, 66, 35);
    test_random_clouds(430, 0, 0);

    // Let the last reports come back, then watch for strays
    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0 && clouds_due.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
